// ===== hdl/asp_pkg.sv =====
package asp_pkg;

  // Input item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  // Result event codes
  localparam logic [1:0] EV_ASN    = 2'd0;
  localparam logic [1:0] EV_EMPTY  = 2'd1;
  localparam logic [1:0] EV_BAD    = 2'd2;
  localparam logic [1:0] EV_NOPATH = 2'd3;

  // Packed port widths
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 96;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [15:0] value_length;
    logic        four_octet_asn;
  } item_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [7:0]  segment_type;
    logic [14:0] segment_number;
    logic [7:0]  asn_position;
    logic [31:0] asn_value;
    logic        last_of_segment;
    logic        last_of_path;
    logic [14:0] total_segments;
    logic [14:0] total_asns;
  } result_t;

endpackage

// ===== hdl/asp_parser.sv =====
module asp_parser
  import asp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_accept,
  input  item_t   item,
  output logic    res_valid,
  output result_t res
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_TYPE  = 2'd1;
  localparam logic [1:0] PH_COUNT = 2'd2;
  localparam logic [1:0] PH_ASN   = 2'd3;

  logic [1:0]  phase, phase_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic        wide_asns, wide_asns_next;
  logic [7:0]  current_type, current_type_next;
  logic [7:0]  asns_left, asns_left_next;
  logic [7:0]  asn_index, asn_index_next;
  logic [1:0]  byte_in_asn, byte_in_asn_next;
  logic [31:0] asn_accumulator, asn_accumulator_next;
  logic [14:0] segment_count, segment_count_next;
  logic [14:0] asn_count, asn_count_next;

  logic        emit;
  logic [1:0]  ev;
  logic [14:0] seg_no;
  logic [7:0]  pos;
  logic [31:0] val;
  logic        last_seg;
  logic        last_path;

  logic [15:0] bytes_dec;
  logic [15:0] list_bytes;
  logic [1:0]  last_byte;
  logic [31:0] acc_shift;
  logic        seg_end;
  logic        path_end;

  assign bytes_dec  = bytes_left - 16'd1;
  assign list_bytes = wide_asns ? {6'd0, item.data_byte, 2'b00}
                                : {7'd0, item.data_byte, 1'b0};
  assign last_byte  = wide_asns ? 2'd3 : 2'd1;
  assign acc_shift  = {asn_accumulator[23:0], item.data_byte};
  assign seg_end    = (asns_left == 8'd1);
  assign path_end   = seg_end && (bytes_dec == 16'd0);

  // Next state and result for the item at the input
  always_comb begin
    phase_next           = phase;
    bytes_left_next      = bytes_left;
    wide_asns_next       = wide_asns;
    current_type_next    = current_type;
    asns_left_next       = asns_left;
    asn_index_next       = asn_index;
    byte_in_asn_next     = byte_in_asn;
    asn_accumulator_next = asn_accumulator;
    segment_count_next   = segment_count;
    asn_count_next       = asn_count;
    emit      = 1'b0;
    ev        = EV_ASN;
    seg_no    = 15'd0;
    pos       = 8'd0;
    val       = 32'd0;
    last_seg  = 1'b0;
    last_path = 1'b0;

    if (item.kind == KIND_START) begin
      // Open a new attribute, abandoning any current one
      bytes_left_next      = item.value_length;
      wide_asns_next       = item.four_octet_asn;
      current_type_next    = 8'd0;
      asns_left_next       = 8'd0;
      asn_index_next       = 8'd0;
      byte_in_asn_next     = 2'd0;
      asn_accumulator_next = 32'd0;
      segment_count_next   = 15'd0;
      asn_count_next       = 15'd0;
      if (item.value_length == 16'd0) begin
        phase_next = PH_IDLE;
        emit       = 1'b1;
        ev         = EV_NOPATH;
        last_path  = 1'b1;
      end else begin
        phase_next = PH_TYPE;
      end
    end else begin
      unique case (phase)
        PH_IDLE: begin
          // drop the byte
        end
        PH_TYPE: begin
          current_type_next = item.data_byte;
          bytes_left_next   = bytes_dec;
          if (bytes_dec == 16'd0) begin
            // header runs past the end
            phase_next = PH_IDLE;
            emit       = 1'b1;
            ev         = EV_BAD;
            seg_no     = segment_count;
            last_path  = 1'b1;
          end else begin
            phase_next = PH_COUNT;
          end
        end
        PH_COUNT: begin
          bytes_left_next = bytes_dec;
          if (list_bytes > bytes_dec) begin
            // ASN list runs past the end
            phase_next = PH_IDLE;
            emit       = 1'b1;
            ev         = EV_BAD;
            seg_no     = segment_count;
            last_path  = 1'b1;
          end else begin
            segment_count_next = segment_count + 15'd1;
            if (item.data_byte == 8'd0) begin
              phase_next = (bytes_dec == 16'd0) ? PH_IDLE : PH_TYPE;
              emit       = 1'b1;
              ev         = EV_EMPTY;
              seg_no     = segment_count;
              last_seg   = 1'b1;
              last_path  = (bytes_dec == 16'd0);
            end else begin
              asns_left_next       = item.data_byte;
              asn_index_next       = 8'd0;
              byte_in_asn_next     = 2'd0;
              asn_accumulator_next = 32'd0;
              phase_next           = PH_ASN;
            end
          end
        end
        PH_ASN: begin
          bytes_left_next = bytes_dec;
          if (byte_in_asn != last_byte) begin
            byte_in_asn_next     = byte_in_asn + 2'd1;
            asn_accumulator_next = acc_shift;
          end else begin
            // ASN complete
            asn_count_next       = asn_count + 15'd1;
            asns_left_next       = asns_left - 8'd1;
            asn_index_next       = asn_index + 8'd1;
            byte_in_asn_next     = 2'd0;
            asn_accumulator_next = 32'd0;
            if (seg_end) begin
              phase_next = path_end ? PH_IDLE : PH_TYPE;
            end
            emit      = 1'b1;
            ev        = EV_ASN;
            seg_no    = segment_count - 15'd1;
            pos       = asn_index;
            val       = acc_shift;
            last_seg  = seg_end;
            last_path = path_end;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // Result fields that read the updated path state
  always_comb begin
    res.event_res       = ev;
    res.segment_type    = current_type_next;
    res.segment_number  = seg_no;
    res.asn_position    = pos;
    res.asn_value       = val;
    res.last_of_segment = last_seg;
    res.last_of_path    = last_path;
    res.total_segments  = segment_count_next;
    res.total_asns      = asn_count_next;
  end

  assign res_valid = in_accept && emit;

  // Advance path state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      bytes_left      <= 16'd0;
      wide_asns       <= 1'b0;
      current_type    <= 8'd0;
      asns_left       <= 8'd0;
      asn_index       <= 8'd0;
      byte_in_asn     <= 2'd0;
      asn_accumulator <= 32'd0;
      segment_count   <= 15'd0;
      asn_count       <= 15'd0;
    end else if (in_accept) begin
      phase           <= phase_next;
      bytes_left      <= bytes_left_next;
      wide_asns       <= wide_asns_next;
      current_type    <= current_type_next;
      asns_left       <= asns_left_next;
      asn_index       <= asn_index_next;
      byte_in_asn     <= byte_in_asn_next;
      asn_accumulator <= asn_accumulator_next;
      segment_count   <= segment_count_next;
      asn_count       <= asn_count_next;
    end
  end

  a_nopath: assert property (@(posedge clk) disable iff (rst)
    in_accept && item.kind == KIND_START && item.value_length == 16'd0
      |-> res_valid && res.event_res == EV_NOPATH && res.last_of_path)
    else $error("zero length start gave no empty path result");

  a_asn_pending: assert property (@(posedge clk) disable iff (rst)
    phase == PH_ASN |-> asns_left != 8'd0)
    else $error("collecting ASNs with none left in segment");

  a_bad_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.event_res == EV_BAD |=> phase == PH_IDLE)
    else $error("parser not idle after malformed result");

  a_narrow_bytes: assert property (@(posedge clk) disable iff (rst)
    phase == PH_ASN && !wide_asns |-> byte_in_asn <= 2'd1)
    else $error("byte index beyond two-octet ASN");

endmodule

// ===== hdl/asp_skid.sv =====
module asp_skid
  import asp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  result_t in_data,
  output logic    in_ready,
  output logic    out_valid,
  output result_t out_data,
  input  logic    out_ready
);

  logic    skid_valid;
  result_t skid_data;
  logic    load_out;

  assign in_ready = !skid_valid;
  assign load_out = out_ready || !out_valid;

  // Track occupancy of output and skid slots
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load_out) begin
      out_valid  <= skid_valid || in_valid;
      skid_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      skid_valid <= 1'b1;
    end
  end

  // Move payload: refill output from skid first, else hold a stalled arrival
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (in_valid && in_ready) begin
      skid_data <= in_data;
    end
  end

endmodule

// ===== hdl/as_path_segment_parser.sv =====
// AS path attribute parser, one attribute value byte per transaction.
//
// Input stream: s_axis_tuser selects the kind of item (0 start, 1 data byte).
// A start carries the value length and the ASN width; data bytes follow.
// Output stream: one result per completed ASN, empty segment, malformed
// header or list, or empty path. m_axis_tuser holds the event code and
// m_axis_tlast marks the final result of the attribute.
//
// A result is registered in the output or skid slot when the byte that
// completes it is accepted. Throughput: one byte per cycle while
// s_axis_tready is high, with a single registered path state step per byte.
//
// Reset clears the path state (the parser drops bytes until a start) and
// empties the output stage. When the receiver stalls, a two-slot output
// stage holds up to two results; s_axis_tready falls only when both are full,
// and it is driven from a register.
module as_path_segment_parser
  import asp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [7:0] data_byte, [23:8] value_length, [24] four_octet_asn, zero fill above
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] kind
  input  logic                   s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [7:0] segment_type, [22:8] segment_number, [30:23] asn_position,
  // [62:31] asn_value, [63] last_of_segment, [78:64] total_segments,
  // [93:79] total_asns, zero fill above
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // [1:0] event_res
  output logic [1:0]             m_axis_tuser,
  // last_of_path
  output logic                   m_axis_tlast
);

  item_t   item;
  logic    in_accept;
  logic    res_valid;
  result_t res;
  result_t out_res;

  // Unpack the input transaction
  assign item.kind           = s_axis_tuser;
  assign item.data_byte      = s_axis_tdata[7:0];
  assign item.value_length   = s_axis_tdata[23:8];
  assign item.four_octet_asn = s_axis_tdata[24];

  assign in_accept = s_axis_tvalid && s_axis_tready;

  asp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_accept (in_accept),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  asp_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (res_valid),
    .in_data   (res),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (out_res),
    .out_ready (m_axis_tready)
  );

  // Pack the output transaction
  assign m_axis_tdata = {2'b00,
                         out_res.total_asns,
                         out_res.total_segments,
                         out_res.last_of_segment,
                         out_res.asn_value,
                         out_res.asn_position,
                         out_res.segment_number,
                         out_res.segment_type};
  assign m_axis_tuser = out_res.event_res;
  assign m_axis_tlast = out_res.last_of_path;

endmodule

// ===== bench/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import asp_pkg::*;

  localparam int RANDOM_ITEMS = 1800;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  // Parser phases of the bench's own path tracker
  typedef enum logic [1:0] {
    P_IDLE  = 2'd0,
    P_TYPE  = 2'd1,
    P_COUNT = 2'd2,
    P_ASN   = 2'd3
  } parse_state_e;

  // How the result of one stimulus row is checked
  typedef enum logic [1:0] {
    CHECK_MODEL = 2'd0,
    CHECK_NONE  = 2'd1,
    CHECK_TYPED = 2'd2
  } check_e;

  typedef struct {
    item_t   it;
    check_e  chk;
    result_t res;
  } directed_row_t;

  typedef struct {
    check_e  chk;
    result_t res;
  } row_check_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]             m_axis_tuser;
  logic                   m_axis_tlast;

  // Path tracker state
  parse_state_e parse_state = P_IDLE;
  logic [15:0]  len_left    = '0;
  logic         wide        = 1'b0;
  logic [7:0]   seg_type    = '0;
  logic [7:0]   asns_to_go  = '0;
  logic [7:0]   asn_pos     = '0;
  int unsigned  asn_byte    = 0;
  logic [31:0]  asn_acc     = '0;
  logic [14:0]  seg_total   = '0;
  logic [14:0]  asn_total   = '0;

  result_t    path_events_due[$];
  row_check_t row_checks[$];
  int         failures      = 0;
  int         counted_items = 0;
  int         quiet_cycles  = 0;
  bit         send_calm     = 1'b0;
  bit         recv_calm     = 1'b0;

  // Directed rows: reset idle byte, extremes, each event and each overrun
  directed_row_t directed_rows[26] = '{
    '{'{KIND_DATA,  8'hFF, 16'h0000, 1'b0}, CHECK_NONE, '0},
    '{'{KIND_START, 8'h00, 16'h0000, 1'b1}, CHECK_TYPED,
      '{EV_NOPATH, 8'h00, 15'd0, 8'd0, 32'd0, 1'b0, 1'b1, 15'd0, 15'd0}},
    '{'{KIND_START, 8'hA5, 16'hFFFF, 1'b1}, CHECK_NONE, '0},
    '{'{KIND_DATA,  8'hFF, 16'hFFFF, 1'b1}, CHECK_NONE, '0},
    '{'{KIND_DATA,  8'h01, 16'h0000, 1'b0}, CHECK_NONE, '0},
    '{'{KIND_DATA,  8'hFF, 16'h0000, 1'b0}, CHECK_NONE, '0},
    '{'{KIND_DATA,  8'hFF, 16'h0000, 1'b0}, CHECK_NONE, '0},
    '{'{KIND_DATA,  8'hFF, 16'h0000, 1'b0}, CHECK_NONE, '0},
    '{'{KIND_DATA,  8'hFF, 16'h0000, 1'b0}, CHECK_TYPED,
      '{EV_ASN, 8'hFF, 15'd0, 8'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, 15'd1, 15'd1}},
    '{'{KIND_START, 8'h00, 16'h0001, 1'b0}, CHECK_NONE, '0},
    '{'{KIND_DATA,  8'h02, 16'h0000, 1'b0}, CHECK_TYPED,
      '{EV_BAD, 8'h02, 15'd0, 8'd0, 32'd0, 1'b0, 1'b1, 15'd0, 15'd0}},
    '{'{KIND_START, 8'h00, 16'h0002, 1'b0}, CHECK_NONE, '0},
    '{'{KIND_DATA,  8'h01, 16'h0000, 1'b0}, CHECK_NONE, '0},
    '{'{KIND_DATA,  8'h00, 16'h0000, 1'b0}, CHECK_TYPED,
      '{EV_EMPTY, 8'h01, 15'd0, 8'd0, 32'd0, 1'b1, 1'b1, 15'd1, 15'd0}},
    '{'{KIND_START, 8'h00, 16'h0004, 1'b0}, CHECK_NONE, '0},
    '{'{KIND_DATA,  8'h02, 16'h0000, 1'b0}, CHECK_NONE, '0},
    '{'{KIND_DATA,  8'h02, 16'h0000, 1'b0}, CHECK_TYPED,
      '{EV_BAD, 8'h02, 15'd0, 8'd0, 32'd0, 1'b0, 1'b1, 15'd0, 15'd0}},
    '{'{KIND_DATA,  8'h77, 16'h0000, 1'b0}, CHECK_NONE, '0},
    '{'{KIND_START, 8'h00, 16'h0007, 1'b0}, CHECK_MODEL, '0},
    '{'{KIND_DATA,  8'h01, 16'h0000, 1'b0}, CHECK_MODEL, '0},
    '{'{KIND_DATA,  8'h00, 16'h0000, 1'b0}, CHECK_MODEL, '0},
    '{'{KIND_DATA,  8'h02, 16'h0000, 1'b0}, CHECK_MODEL, '0},
    '{'{KIND_DATA,  8'h01, 16'h0000, 1'b0}, CHECK_MODEL, '0},
    '{'{KIND_DATA,  8'h12, 16'h0000, 1'b0}, CHECK_MODEL, '0},
    '{'{KIND_DATA,  8'h34, 16'h0000, 1'b0}, CHECK_MODEL, '0},
    '{'{KIND_DATA,  8'h03, 16'h0000, 1'b0}, CHECK_MODEL, '0}
  };

  as_path_segment_parser i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Build one path event with the running path fields filled in
  function automatic result_t path_event(logic [1:0] ev, logic [14:0] seg_no,
                                         logic [7:0] pos, logic [31:0] val,
                                         logic last_seg, logic last_path);
    result_t r;
    r.event_res       = ev;
    r.segment_type    = seg_type;
    r.segment_number  = seg_no;
    r.asn_position    = pos;
    r.asn_value       = val;
    r.last_of_segment = last_seg;
    r.last_of_path    = last_path;
    r.total_segments  = seg_total;
    r.total_asns      = asn_total;
    return r;
  endfunction

  // Advance the path tracker by one transaction; return 1 when it yields an event
  function automatic bit parse_byte(input item_t it, output result_t r);
    int unsigned asn_len;
    logic [14:0] seg_no;
    bit          seg_end;
    bit          path_end;
    r = '0;
    if (it.kind == KIND_START) begin
      len_left   = it.value_length;
      wide       = it.four_octet_asn;
      seg_type   = '0;
      asns_to_go = '0;
      asn_pos    = '0;
      asn_byte   = 0;
      asn_acc    = '0;
      seg_total  = '0;
      asn_total  = '0;
      if (len_left == 16'd0) begin
        parse_state = P_IDLE;
        r = path_event(EV_NOPATH, '0, '0, '0, 1'b0, 1'b1);
        return 1'b1;
      end
      parse_state = P_TYPE;
      return 1'b0;
    end
    asn_len = wide ? 4 : 2;
    case (parse_state)
      P_TYPE: begin
        seg_type = it.data_byte;
        len_left = len_left - 16'd1;
        if (len_left == 16'd0) begin
          parse_state = P_IDLE;
          r = path_event(EV_BAD, seg_total, '0, '0, 1'b0, 1'b1);
          return 1'b1;
        end
        parse_state = P_COUNT;
        return 1'b0;
      end
      P_COUNT: begin
        len_left = len_left - 16'd1;
        if (int'(it.data_byte) * asn_len > int'(len_left)) begin
          parse_state = P_IDLE;
          r = path_event(EV_BAD, seg_total, '0, '0, 1'b0, 1'b1);
          return 1'b1;
        end
        seg_no    = seg_total;
        seg_total = seg_total + 15'd1;
        if (it.data_byte == 8'd0) begin
          path_end    = (len_left == 16'd0);
          parse_state = path_end ? P_IDLE : P_TYPE;
          r = path_event(EV_EMPTY, seg_no, '0, '0, 1'b1, path_end);
          return 1'b1;
        end
        asns_to_go  = it.data_byte;
        asn_pos     = '0;
        asn_byte    = 0;
        asn_acc     = '0;
        parse_state = P_ASN;
        return 1'b0;
      end
      P_ASN: begin
        asn_acc  = {asn_acc[23:0], it.data_byte};
        len_left = len_left - 16'd1;
        if (asn_byte + 1 < asn_len) begin
          asn_byte++;
          return 1'b0;
        end
        seg_no     = seg_total - 15'd1;
        asn_total  = asn_total + 15'd1;
        asns_to_go = asns_to_go - 8'd1;
        seg_end    = (asns_to_go == 8'd0);
        path_end   = seg_end && (len_left == 16'd0);
        if (seg_end) parse_state = path_end ? P_IDLE : P_TYPE;
        r = path_event(EV_ASN, seg_no, asn_pos, asn_acc, seg_end, path_end);
        asn_pos  = asn_pos + 8'd1;
        asn_byte = 0;
        asn_acc  = '0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      failures++;
    end
  endfunction

  // Drive one transaction after a random gap and hold it until accepted
  task automatic send_item(input item_t it, input check_e chk, input result_t res);
    int unsigned gap;
    if ($urandom_range(0, 63) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    row_checks.push_back('{chk, res});
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.kind;
    s_axis_tdata  <= {7'b0, it.four_octet_asn, it.value_length, it.data_byte};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Send one random attribute: mostly well formed, some with broken length or body
  task automatic send_attribute();
    logic [7:0]  body[$];
    bit          four;
    int          nseg;
    int          cnt;
    int          r;
    int          cut;
    logic [15:0] len;
    item_t       it;
    four = 1'($urandom_range(0, 1));
    nseg = $urandom_range(0, 4);
    repeat (nseg) begin
      body.push_back(8'($urandom_range(0, 255)));
      r = $urandom_range(0, 99);
      cnt = (r < 8) ? 0 : (r < 99) ? $urandom_range(1, 6) : $urandom_range(7, 255);
      body.push_back(8'(cnt));
      repeat (cnt * (four ? 4 : 2)) body.push_back(8'($urandom_range(0, 255)));
    end
    len = 16'(body.size());
    r = $urandom_range(0, 99);
    if (r >= 70 && r < 78) begin
      // short length: overruns or an early end
      if (len > 0) len = 16'($urandom_range(0, len - 1));
    end else if (r >= 78 && r < 84) begin
      // long length: body runs out, next start abandons
      len = len + 16'($urandom_range(1, 3));
    end else if (r >= 84 && r < 88) begin
      // cut body short
      cut = (body.size() > 0) ? $urandom_range(0, body.size() - 1) : 0;
      while (body.size() > cut) void'(body.pop_back());
    end else if (r >= 88 && r < 92) begin
      // random length with a noise body
      len = 16'($urandom_range(0, 65535));
      repeat ($urandom_range(0, 12)) body.push_back(8'($urandom_range(0, 255)));
    end else if (r >= 92) begin
      // stray bytes after the path ends
      repeat ($urandom_range(1, 4)) body.push_back(8'($urandom_range(0, 255)));
    end
    it.kind           = KIND_START;
    it.data_byte      = 8'($urandom_range(0, 255));
    it.value_length   = len;
    it.four_octet_asn = four;
    send_item(it, CHECK_MODEL, '0);
    foreach (body[i]) begin
      it.kind           = KIND_DATA;
      it.data_byte      = body[i];
      it.value_length   = 16'($urandom_range(0, 65535));
      it.four_octet_asn = 1'($urandom_range(0, 1));
      send_item(it, CHECK_MODEL, '0);
    end
  endtask

  // Stimulus: reset, directed table, random attributes, drain
  initial begin
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i])
      send_item(directed_rows[i].it, directed_rows[i].chk, directed_rows[i].res);
    while (counted_items < RANDOM_ITEMS) send_attribute();
    s_axis_tvalid <= 1'b0;
    while (path_events_due.size() != 0 || row_checks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("as_path_segment_parser test passed");
    end else begin
      $display("as_path_segment_parser test failed");
    end
    $finish;
  end

  // Receiver: stall a random number of cycles before each result
  initial begin
    int unsigned gap;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) recv_calm = !recv_calm;
      gap = recv_calm ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  // Predict on accepted input, compare accepted output with the oldest event due
  always @(posedge clk) begin : monitor
    item_t      acc;
    result_t    model_res;
    result_t    got;
    result_t    want;
    row_check_t row;
    bit         produced;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        acc.kind           = s_axis_tuser;
        acc.data_byte      = s_axis_tdata[7:0];
        acc.value_length   = s_axis_tdata[23:8];
        acc.four_octet_asn = s_axis_tdata[24];
        row = row_checks.pop_front();
        if (!(acc.kind == KIND_DATA && parse_state == P_IDLE)) counted_items++;
        produced = parse_byte(acc, model_res);
        if (row.chk == CHECK_TYPED) path_events_due.push_back(row.res);
        else if (row.chk == CHECK_MODEL && produced) path_events_due.push_back(model_res);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.event_res       = m_axis_tuser;
        got.segment_type    = m_axis_tdata[7:0];
        got.segment_number  = m_axis_tdata[22:8];
        got.asn_position    = m_axis_tdata[30:23];
        got.asn_value       = m_axis_tdata[62:31];
        got.last_of_segment = m_axis_tdata[63];
        got.last_of_path    = m_axis_tlast;
        got.total_segments  = m_axis_tdata[78:64];
        got.total_asns      = m_axis_tdata[93:79];
        if (path_events_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual event %0h value %0h",
                   $time, got.event_res, got.asn_value);
          failures++;
        end else begin
          want = path_events_due.pop_front();
          check_field("event_res", 32'(want.event_res), 32'(got.event_res));
          check_field("segment_type", 32'(want.segment_type), 32'(got.segment_type));
          check_field("segment_number", 32'(want.segment_number), 32'(got.segment_number));
          check_field("asn_position", 32'(want.asn_position), 32'(got.asn_position));
          check_field("asn_value", want.asn_value, got.asn_value);
          check_field("last_of_segment", 32'(want.last_of_segment),
                      32'(got.last_of_segment));
          check_field("last_of_path", 32'(want.last_of_path), 32'(got.last_of_path));
          check_field("total_segments", 32'(want.total_segments), 32'(got.total_segments));
          check_field("total_asns", 32'(want.total_asns), 32'(got.total_asns));
          check_field("tdata fill", 32'd0, 32'(m_axis_tdata[95:94]));
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("as_path_segment_parser test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
